/* design/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants, types and control structs for the sorted store block.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP_RD,
        ST_LOOKUP_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item, open search window
        logic rd_mid;    // read entry at search midpoint
        logic cmp;       // narrow search window
        logic rd_shift;  // read entry below shift index
        logic wr_shift;  // move read entry up one place
        logic place;     // write new value, bump count
        logic res_load;  // load output register
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic search_done;
        logic shift_done;
        logic query;
        logic full;
    } stat_t;

endpackage

/* design/ssc_if.sv */
// ----------------------------------------------------------------------------
// ssc_req_if / ssc_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface ssc_req_if;
    logic          valid;
    logic          ready;
    logic          operation;
    ssc_pkg::data_t value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface ssc_rsp_if;
    logic            valid;
    logic            ready;
    ssc_pkg::count_t count;
    logic            store_full;

    modport source (output valid, output count, output store_full, input ready);
    modport sink   (input valid, input count, input store_full, output ready);
endinterface

/* design/ssc_datapath.sv */
// ----------------------------------------------------------------------------
// ssc_datapath
// Entry memory, search window, shift index, entry count and result register.
// ----------------------------------------------------------------------------
module ssc_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  ssc_pkg::ctrl_t  cmd,
    output ssc_pkg::stat_t  stat,
    input  logic            operation,
    input  ssc_pkg::data_t  value,
    output ssc_pkg::count_t count,
    output logic            store_full
);

    ssc_pkg::data_t mem [ssc_pkg::DEPTH];

    logic            op_reg,  op_next;
    ssc_pkg::data_t  key_reg, key_next;
    logic            full_reg, full_next;
    ssc_pkg::idx_t   lo_reg,  lo_next;
    ssc_pkg::idx_t   hi_reg,  hi_next;
    ssc_pkg::idx_t   idx_reg, idx_next;
    ssc_pkg::idx_t   count_reg, count_next;
    ssc_pkg::count_t out_count_reg, out_count_next;
    logic            out_full_reg, out_full_next;
    ssc_pkg::data_t  rd_data_reg;

    ssc_pkg::idx_t   mid;
    ssc_pkg::idx_t   idx_dn;
    ssc_pkg::addr_t  rd_addr;
    ssc_pkg::addr_t  wr_addr;
    ssc_pkg::data_t  wr_data;
    logic            wr_en;
    logic            rd_en;
    logic            count_is_full;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dn = idx_reg - ssc_pkg::idx_t'(1);
    assign count_is_full = (count_reg >= ssc_pkg::idx_t'(ssc_pkg::DEPTH));

    // read port: midpoint during search, entry below index during shift
    assign rd_en   = cmd.rd_mid | cmd.rd_shift;
    assign rd_addr = cmd.rd_shift ? ssc_pkg::addr_t'(idx_dn) : ssc_pkg::addr_t'(mid);
    assign wr_en   = cmd.wr_shift | cmd.place;
    assign wr_addr = cmd.wr_shift ? ssc_pkg::addr_t'(idx_reg) : ssc_pkg::addr_t'(lo_reg);
    assign wr_data = cmd.wr_shift ? rd_data_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        full_next      = full_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        out_count_next = out_count_reg;
        out_full_next  = out_full_reg;

        if (cmd.load)
        begin
            op_next   = operation;
            key_next  = value;
            full_next = count_is_full;
            lo_next   = '0;
            hi_next   = count_reg;
            idx_next  = count_reg;
        end
        if (cmd.cmp)
        begin
            if (rd_data_reg <= key_reg)
            begin
                lo_next = mid + ssc_pkg::idx_t'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.wr_shift)
        begin
            idx_next = idx_dn;
        end
        if (cmd.place)
        begin
            count_next = count_reg + ssc_pkg::idx_t'(1);
        end
        if (cmd.res_load)
        begin
            if (op_reg == ssc_pkg::OP_QUERY)
            begin
                out_count_next = ssc_pkg::count_t'(lo_reg);
                out_full_next  = 1'b0;
            end
            else
            begin
                out_count_next = ssc_pkg::count_t'(count_reg);
                out_full_next  = full_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        full_reg      <= full_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        idx_reg       <= idx_next;
        out_count_reg <= out_count_next;
        out_full_reg  <= out_full_next;
    end

    assign stat.search_done = (lo_reg >= hi_reg);
    assign stat.shift_done  = (idx_reg == lo_reg);
    assign stat.query       = (op_reg == ssc_pkg::OP_QUERY);
    assign stat.full        = full_reg;

    assign count      = out_count_reg;
    assign store_full = out_full_reg;

endmodule

/* design/ssc_controller.sv */
// ----------------------------------------------------------------------------
// ssc_controller
// Sequencer: search, shift, place, result hand-off; owns result valid.
// ----------------------------------------------------------------------------
module ssc_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  ssc_pkg::stat_t stat,
    output ssc_pkg::ctrl_t cmd
);

    ssc_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ssc_pkg::ST_LOOKUP_RD;
                end
            end
            ssc_pkg::ST_LOOKUP_RD:
            begin
                if (!stat.search_done)
                begin
                    state_next = ssc_pkg::ST_LOOKUP_CMP;
                end
                else if (stat.query || stat.full)
                begin
                    state_next = ssc_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = ssc_pkg::ST_SHIFT_RD;
                end
            end
            ssc_pkg::ST_LOOKUP_CMP: state_next = ssc_pkg::ST_LOOKUP_RD;
            ssc_pkg::ST_SHIFT_RD:
            begin
                state_next = stat.shift_done ? ssc_pkg::ST_PLACE : ssc_pkg::ST_SHIFT_WR;
            end
            ssc_pkg::ST_SHIFT_WR:   state_next = ssc_pkg::ST_SHIFT_RD;
            ssc_pkg::ST_PLACE:      state_next = ssc_pkg::ST_FINISH;
            ssc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ssc_pkg::ST_IDLE;
                end
            end
            default:                state_next = ssc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ssc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ssc_pkg::ST_LOOKUP_RD:  cmd.rd_mid   = !stat.search_done;
            ssc_pkg::ST_LOOKUP_CMP: cmd.cmp      = 1'b1;
            ssc_pkg::ST_SHIFT_RD:   cmd.rd_shift = !stat.shift_done;
            ssc_pkg::ST_SHIFT_WR:   cmd.wr_shift = 1'b1;
            ssc_pkg::ST_PLACE:      cmd.place    = 1'b1;
            ssc_pkg::ST_FINISH:     cmd.res_load = out_free;
            default:                cmd          = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/sorted_store_count_at_most.sv */
// ----------------------------------------------------------------------------
// sorted_store_count_at_most
// Sorted 32-bit value store with insert and upper-bound count queries.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: operation (0 insert, 1 query) and a 32-bit value.
//   rsp returns one item per request: count and store_full.
//   Insert puts the value after any equal values already held; the result
//   gives the new entry count. If the store already holds DEPTH entries the
//   value is dropped, store_full is set and count is the unchanged total.
//   Query returns the number of held values <= value; store_full is 0.
// Timing:
//   One item at a time. A search takes s steps (memory read, then compare),
//   s at most floor(log2(count))+1, and ends once the search window is empty.
//   A query's result is loaded in the finish state; req is ready again in
//   the same cycle that rsp.valid rises. An insert first moves each entry
//   above its slot up one place (read, then write), then writes the value.
// Reset:
//   Entry count clears to zero; memory contents are not cleared and no
//   unwritten entry is ever read.
// Stall:
//   The result sits in an output register; req is free again as soon as it
//   is loaded. A following result waits in its last state until rsp drains.
// ----------------------------------------------------------------------------
module sorted_store_count_at_most (
    input  logic      clk,
    input  logic      rst_n,
    ssc_req_if.sink   req,
    ssc_rsp_if.source rsp
);

    ssc_pkg::ctrl_t cmd;
    ssc_pkg::stat_t stat;

    ssc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ssc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .operation  (req.operation),
        .value      (req.value),
        .count      (rsp.count),
        .store_full (rsp.store_full)
    );

endmodule
